/* rtl/otq_pkg.sv */
// Shared types and constants for the ordered timer queue.
`default_nettype none
package otq_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_RESULTS = 16;
	localparam int TW = 63;
	localparam int IW = 32;
	localparam int BW = $clog2(MAX_RESULTS);
	localparam int CW = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_CANCEL = 2'd1,
		ACT_TICK   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		KIND_ADD     = 2'd0,
		KIND_CANCEL  = 2'd1,
		KIND_EXPIRED = 2'd2,
		KIND_IDLE    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_CANCEL,
		ST_POP,
		ST_CALC,
		ST_PLACE,
		ST_EMIT,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic latch;
		logic do_add;
		logic do_cancel;
		logic do_pop;
		logic do_calc;
		logic do_place;
		logic ptr_clr;
		logic ptr_inc;
		logic emit_reply;
		logic emit_expired;
	} cmd_t;

	typedef struct packed {
		logic head_due;
		logic buf_full;
		logic buf_empty;
		logic ptr_end;
		logic ptr_last;
		logic iv_zero;
	} status_t;
endpackage
`default_nettype wire

/* rtl/ordered_timer_queue_unit.sv */
// Top level of the ordered timer queue: controller plus datapath.
// A request is taken when start is high and busy is low. Add and cancel each
// pass through their own state and then the reply state to a single result. A
// tick pops expired timers from the head of the sorted chain into the expiry
// buffer until none is due or the buffer is full, then walks the popped timers
// and restarts each repeating one (restart sum, then chain insert), then emits
// one result per popped timer, each result registered from its emit state; a
// tick with nothing due answers with a single idle result.
// Each result sits on the outputs for exactly one cycle, flagged by strobe,
// and the receiver cannot stall it. The chain shifts one slot per insert or
// removal.
`default_nettype none
module ordered_timer_queue_unit (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	output logic                        busy,
	input  wire [1:0]                   action,
	input  wire [otq_pkg::TW-1:0]       expire_time,
	input  wire [otq_pkg::TW-1:0]       repeat_interval,
	input  wire [otq_pkg::IW-1:0]       timer_id,
	input  wire [otq_pkg::TW-1:0]       now_time,
	output logic                        strobe,
	output logic [1:0]                  kind,
	output logic [otq_pkg::IW-1:0]      result_id,
	output logic                        ok,
	output logic                        became_earliest,
	output logic [otq_pkg::TW-1:0]      next_deadline,
	output logic                        next_valid,
	output logic                        last
);
	otq_pkg::cmd_t    cmd;
	otq_pkg::status_t status;

	otq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	otq_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.action           (action),
		.expire_time      (expire_time),
		.repeat_interval  (repeat_interval),
		.timer_id         (timer_id),
		.now_time         (now_time),
		.strobe           (strobe),
		.kind             (kind),
		.result_id        (result_id),
		.ok               (ok),
		.became_earliest  (became_earliest),
		.next_deadline    (next_deadline),
		.next_valid       (next_valid),
		.last             (last)
	);

	// Expired results always report success
	a_exp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == otq_pkg::KIND_EXPIRED |-> ok && !became_earliest)
		else $error("expired result without ok");

	// Only expiry bursts carry results that are not last
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> kind == otq_pkg::KIND_EXPIRED)
		else $error("non-last result outside an expiry burst");

	// An empty queue reports a zero deadline
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !next_valid |-> next_deadline == '0)
		else $error("empty queue with nonzero deadline");

	// A final result frees the block on the same cycle
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("busy after final result");
endmodule
`default_nettype wire

/* rtl/otq_ctrl.sv */
// Sequencing state machine for the ordered timer queue.
`default_nettype none
module otq_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire [1:0]               action,
	input  otq_pkg::status_t        status,
	output otq_pkg::cmd_t           cmd,
	output logic                    busy
);
	otq_pkg::state_t state_q, state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= otq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Choose the next state and drive commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != otq_pkg::ST_IDLE);
		case (state_q)
			otq_pkg::ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					case (action)
						otq_pkg::ACT_ADD:    state_d = otq_pkg::ST_ADD;
						otq_pkg::ACT_CANCEL: state_d = otq_pkg::ST_CANCEL;
						otq_pkg::ACT_TICK:   state_d = otq_pkg::ST_POP;
						default:             state_d = otq_pkg::ST_IDLE;
					endcase
				end
			end
			otq_pkg::ST_ADD: begin
				cmd.do_add = 1'b1;
				state_d = otq_pkg::ST_REPLY;
			end
			otq_pkg::ST_CANCEL: begin
				cmd.do_cancel = 1'b1;
				state_d = otq_pkg::ST_REPLY;
			end
			otq_pkg::ST_POP: begin
				// Pull expired timers off the head
				if (status.head_due && !status.buf_full) begin
					cmd.do_pop = 1'b1;
				end else if (status.buf_empty) begin
					state_d = otq_pkg::ST_REPLY;
				end else begin
					cmd.ptr_clr = 1'b1;
					state_d = otq_pkg::ST_CALC;
				end
			end
			otq_pkg::ST_CALC: begin
				// Walk the popped timers, restart the repeating ones
				if (status.ptr_end) begin
					cmd.ptr_clr = 1'b1;
					state_d = otq_pkg::ST_EMIT;
				end else if (status.iv_zero) begin
					cmd.ptr_inc = 1'b1;
				end else begin
					cmd.do_calc = 1'b1;
					state_d = otq_pkg::ST_PLACE;
				end
			end
			otq_pkg::ST_PLACE: begin
				cmd.do_place = 1'b1;
				cmd.ptr_inc = 1'b1;
				state_d = otq_pkg::ST_CALC;
			end
			otq_pkg::ST_EMIT: begin
				cmd.emit_expired = 1'b1;
				cmd.ptr_inc = 1'b1;
				if (status.ptr_last) begin
					state_d = otq_pkg::ST_IDLE;
				end
			end
			otq_pkg::ST_REPLY: begin
				cmd.emit_reply = 1'b1;
				state_d = otq_pkg::ST_IDLE;
			end
			default: begin
				state_d = otq_pkg::ST_IDLE;
			end
		endcase
	end
endmodule
`default_nettype wire

/* rtl/otq_datapath.sv */
// Sorted timer chain, expiry buffer and result registers.
`default_nettype none
module otq_datapath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  otq_pkg::cmd_t                cmd,
	output otq_pkg::status_t             status,
	input  wire [1:0]                    action,
	input  wire [otq_pkg::TW-1:0]        expire_time,
	input  wire [otq_pkg::TW-1:0]        repeat_interval,
	input  wire [otq_pkg::IW-1:0]        timer_id,
	input  wire [otq_pkg::TW-1:0]        now_time,
	output logic                         strobe,
	output logic [1:0]                   kind,
	output logic [otq_pkg::IW-1:0]       result_id,
	output logic                         ok,
	output logic                         became_earliest,
	output logic [otq_pkg::TW-1:0]       next_deadline,
	output logic                         next_valid,
	output logic                         last
);
	localparam int D = otq_pkg::QUEUE_DEPTH;

	// Request registers
	logic [1:0]               act_q;
	logic [otq_pkg::TW-1:0]   exp_q, rep_q, now_q;
	logic [otq_pkg::IW-1:0]   tid_q;

	// Timer chain, head at index zero
	logic [otq_pkg::TW-1:0]   dl_q [D];
	logic [otq_pkg::TW-1:0]   iv_q [D];
	logic [otq_pkg::IW-1:0]   id_q [D];
	logic [D-1:0]             vld_q;
	logic [otq_pkg::IW-1:0]   next_id_q;

	// Expiry buffer
	logic [otq_pkg::IW-1:0]   buf_id [otq_pkg::MAX_RESULTS];
	logic [otq_pkg::TW-1:0]   buf_iv [otq_pkg::MAX_RESULTS];
	logic [otq_pkg::CW-1:0]   cnt_q, ptr_q;
	logic [otq_pkg::TW-1:0]   nd_q;

	// Reply flags
	logic                     rok_q, rec_q;
	logic [otq_pkg::IW-1:0]   rid_q;

	// Result registers
	logic                     strobe_q, ok_q, ec_q, last_q, nv_q;
	logic [1:0]               kind_q;
	logic [otq_pkg::IW-1:0]   res_id_q;
	logic [otq_pkg::TW-1:0]   nxt_q;

	logic [otq_pkg::TW-1:0]   p_dl, p_iv;
	logic [otq_pkg::IW-1:0]   p_id;
	logic [D-1:0]             le, hit, drop_m;
	logic                     full, any_hit, place_en, drop_en;
	logic [otq_pkg::BW-1:0]   ptr_ix;
	logic [otq_pkg::TW:0]     sum;

	assign ptr_ix = ptr_q[otq_pkg::BW-1:0];
	assign full = vld_q[D-1];
	assign sum = {1'b0, now_q} + {1'b0, buf_iv[ptr_ix]};

	// Select what gets placed into the chain
	always_comb begin
		if (cmd.do_place) begin
			p_dl = nd_q;
			p_iv = buf_iv[ptr_ix];
			p_id = buf_id[ptr_ix];
		end else begin
			p_dl = exp_q;
			p_iv = rep_q;
			p_id = next_id_q;
		end
	end

	// Compare every slot against the new deadline and the cancel id
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int i = 0; i < D; i++) begin
			le[i] = vld_q[i] && (dl_q[i] <= p_dl);
			hit[i] = vld_q[i] && (id_q[i] == tid_q);
			seen = seen | hit[i];
			drop_m[i] = cmd.do_pop | seen;
		end
		any_hit = seen;
	end

	assign place_en = cmd.do_place | (cmd.do_add & ~full);
	assign drop_en = cmd.do_pop | (cmd.do_cancel & any_hit);

	// Shift the chain to insert or remove
	always_ff @(posedge clk) begin
		if (place_en) begin
			if (!le[0]) begin
				dl_q[0] <= p_dl;
				iv_q[0] <= p_iv;
				id_q[0] <= p_id;
			end
			for (int i = 1; i < D; i++) begin
				if (!le[i]) begin
					if (le[i-1]) begin
						dl_q[i] <= p_dl;
						iv_q[i] <= p_iv;
						id_q[i] <= p_id;
					end else begin
						dl_q[i] <= dl_q[i-1];
						iv_q[i] <= iv_q[i-1];
						id_q[i] <= id_q[i-1];
					end
				end
			end
		end else if (drop_en) begin
			for (int i = 0; i < D - 1; i++) begin
				if (drop_m[i]) begin
					dl_q[i] <= dl_q[i+1];
					iv_q[i] <= iv_q[i+1];
					id_q[i] <= id_q[i+1];
				end
			end
		end
	end

	// Track occupancy and the id counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			next_id_q <= '0;
		end else begin
			if (place_en) begin
				vld_q <= {vld_q[D-2:0], 1'b1} | vld_q;
			end else if (drop_en) begin
				vld_q <= vld_q >> 1;
			end
			if (cmd.do_add && !full) begin
				next_id_q <= next_id_q + 1'b1;
			end
		end
	end

	// Capture the request and keep reply flags
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			act_q <= action;
			exp_q <= expire_time;
			rep_q <= repeat_interval;
			tid_q <= timer_id;
			now_q <= now_time;
		end
		if (cmd.do_add) begin
			rok_q <= ~full;
			rec_q <= ~full & ~le[0];
			rid_q <= full ? '0 : next_id_q;
		end
		if (cmd.do_cancel) begin
			rok_q <= any_hit;
			rec_q <= 1'b0;
			rid_q <= tid_q;
		end
		if (cmd.do_pop) begin
			buf_id[cnt_q[otq_pkg::BW-1:0]] <= id_q[0];
			buf_iv[cnt_q[otq_pkg::BW-1:0]] <= iv_q[0];
		end
		// Saturate the restart deadline
		if (cmd.do_calc) begin
			nd_q <= sum[otq_pkg::TW] ? {otq_pkg::TW{1'b1}} : sum[otq_pkg::TW-1:0];
		end
	end

	// Advance the buffer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.latch) begin
				cnt_q <= '0;
			end else if (cmd.do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_comb begin
		status.head_due = vld_q[0] && (dl_q[0] < now_q);
		status.buf_full = (cnt_q == otq_pkg::CW'(otq_pkg::MAX_RESULTS));
		status.buf_empty = (cnt_q == '0);
		status.ptr_end = (ptr_q == cnt_q);
		status.ptr_last = (ptr_q + 1'b1 == cnt_q);
		status.iv_zero = (buf_iv[ptr_ix] == '0);
	end

	// Load a result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit_reply | cmd.emit_expired;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_reply || cmd.emit_expired) begin
			nxt_q <= vld_q[0] ? dl_q[0] : '0;
			nv_q <= vld_q[0];
		end
		if (cmd.emit_expired) begin
			kind_q <= otq_pkg::KIND_EXPIRED;
			res_id_q <= buf_id[ptr_ix];
			ok_q <= 1'b1;
			ec_q <= 1'b0;
			last_q <= status.ptr_last;
		end else if (cmd.emit_reply) begin
			last_q <= 1'b1;
			case (act_q)
				otq_pkg::ACT_ADD: begin
					kind_q <= otq_pkg::KIND_ADD;
					res_id_q <= rid_q;
					ok_q <= rok_q;
					ec_q <= rec_q;
				end
				otq_pkg::ACT_CANCEL: begin
					kind_q <= otq_pkg::KIND_CANCEL;
					res_id_q <= rid_q;
					ok_q <= rok_q;
					ec_q <= 1'b0;
				end
				default: begin
					kind_q <= otq_pkg::KIND_IDLE;
					res_id_q <= '0;
					ok_q <= 1'b0;
					ec_q <= 1'b0;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign kind = kind_q;
	assign result_id = res_id_q;
	assign ok = ok_q;
	assign became_earliest = ec_q;
	assign next_deadline = nxt_q;
	assign next_valid = nv_q;
	assign last = last_q;
endmodule
`default_nettype wire

/* dv/tb_ordered_timer_queue_unit.sv */
// Self-checking testbench for the ordered timer queue: directed and random requests.
`timescale 1ns / 1ps
`default_nettype none
module tb_ordered_timer_queue_unit;
	localparam logic [62:0] TMAX = {63{1'b1}};

	typedef struct {
		otq_pkg::action_t act;
		logic [62:0]  dl;
		logic [62:0]  iv;
		logic [31:0]  tid;
		logic [62:0]  now;
	} req_t;

	typedef struct {
		otq_pkg::kind_t k;
		logic [31:0]  id;
		logic         ok;
		logic         ec;
		logic [62:0]  nd;
		logic         nv;
		logic         lst;
	} reply_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [1:0] action = '0;
	logic [62:0] expire_time = '0, repeat_interval = '0, now_time = '0;
	logic [31:0] timer_id = '0;
	wire busy, strobe, ok, became_earliest, next_valid, last;
	wire [1:0] kind;
	wire [31:0] result_id;
	wire [62:0] next_deadline;

	ordered_timer_queue_unit dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Shadow copy of the sorted chain
	logic [62:0] q_dl[$];
	logic [62:0] q_iv[$];
	logic [31:0] q_id[$];
	logic [31:0] id_next = 0;

	req_t   pending_reqs[$];
	reply_t expected_replies[$];
	int errors = 0;
	bit feeding_done = 0;

	function automatic bit insert_timer(logic [62:0] d, logic [62:0] v, logic [31:0] i);
		int pos;
		bit ec;
		pos = 0;
		ec = (q_dl.size() == 0) || (d < q_dl[0]);
		while (pos < q_dl.size() && q_dl[pos] <= d) pos++;
		q_dl.insert(pos, d);
		q_iv.insert(pos, v);
		q_id.insert(pos, i);
		return ec;
	endfunction

	function automatic void push_reply(otq_pkg::kind_t k, logic [31:0] id, logic o,
			logic ec, logic lst);
		reply_t r;
		r.k = k; r.id = id; r.ok = o; r.ec = ec; r.lst = lst;
		r.nv = q_dl.size() != 0;
		r.nd = r.nv ? q_dl[0] : '0;
		expected_replies.push_back(r);
	endfunction

	// Work out the replies of one accepted request
	function automatic void predict_timer_queue(req_t r);
		logic [31:0] ids[$];
		logic [62:0] ivs[$];
		logic [63:0] sum;
		int found;
		bit ec;
		case (r.act)
			otq_pkg::ACT_ADD: begin
				if (q_dl.size() >= otq_pkg::QUEUE_DEPTH)
					push_reply(otq_pkg::KIND_ADD, 0, 0, 0, 1);
				else begin
					ec = insert_timer(r.dl, r.iv, id_next);
					push_reply(otq_pkg::KIND_ADD, id_next, 1, ec, 1);
					id_next++;
				end
			end
			otq_pkg::ACT_CANCEL: begin
				found = -1;
				foreach (q_id[i]) if (found < 0 && q_id[i] == r.tid) found = i;
				if (found >= 0) begin
					q_dl.delete(found); q_iv.delete(found); q_id.delete(found);
				end
				push_reply(otq_pkg::KIND_CANCEL, r.tid, found >= 0, 0, 1);
			end
			otq_pkg::ACT_TICK: begin
				while (ids.size() < otq_pkg::MAX_RESULTS && q_dl.size() > 0
						&& q_dl[0] < r.now) begin
					ids.push_back(q_id.pop_front());
					ivs.push_back(q_iv.pop_front());
					void'(q_dl.pop_front());
				end
				foreach (ids[i]) if (ivs[i] != 0) begin
					sum = {1'b0, r.now} + {1'b0, ivs[i]};
					void'(insert_timer(sum > {1'b0, TMAX} ? TMAX : sum[62:0], ivs[i], ids[i]));
				end
				if (ids.size() == 0) push_reply(otq_pkg::KIND_IDLE, 0, 0, 0, 1);
				else foreach (ids[i])
					push_reply(otq_pkg::KIND_EXPIRED, ids[i], 1, 0, i == ids.size() - 1);
			end
			default: ;
		endcase
	endfunction

	function automatic int short_or_long_gap();
		if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// Feed pending requests, with random gaps
	int gap = 0;
	bit issued = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				predict_timer_queue(pending_reqs.pop_front());
				issued = 1;
			end else issued = 0;
			if (start && busy) ;
			else if (gap > 0) begin
				gap--;
				start <= 0;
			end else if (pending_reqs.size() > 0 && !(issued && pending_reqs.size() == 0)) begin
				start <= 1;
				action <= pending_reqs[0].act;
				expire_time <= pending_reqs[0].dl;
				repeat_interval <= pending_reqs[0].iv;
				timer_id <= pending_reqs[0].tid;
				now_time <= pending_reqs[0].now;
				gap = short_or_long_gap();
				if (gap > 0 && $urandom_range(0, 1)) gap = 0;
			end else start <= 0;
			if (pending_reqs.size() == 0 && !(start && busy) && feeding_done) ;
		end
	end

	// Compare each strobed reply with the oldest expectation
	always @(posedge clk) begin
		reply_t e;
		if (arst_n && strobe) begin
			if (expected_replies.size() == 0) begin
				$error("unexpected reply kind=%0d id=%0d", kind, result_id);
				errors++;
			end else begin
				e = expected_replies.pop_front();
				if (kind !== e.k) begin
					$error("kind exp %0d got %0d", e.k, kind); errors++; end
				if (result_id !== e.id) begin
					$error("result_id exp %0d got %0d", e.id, result_id); errors++; end
				if (ok !== e.ok) begin
					$error("ok exp %0d got %0d", e.ok, ok); errors++; end
				if (became_earliest !== e.ec) begin
					$error("became_earliest exp %0d got %0d", e.ec, became_earliest);
					errors++;
				end
				if (next_deadline !== e.nd) begin
					$error("next_deadline exp %0h got %0h", e.nd, next_deadline); errors++; end
				if (next_valid !== e.nv) begin
					$error("next_valid exp %0d got %0d", e.nv, next_valid); errors++; end
				if (last !== e.lst) begin
					$error("last exp %0d got %0d", e.lst, last); errors++; end
			end
		end
	end

	function automatic req_t mk(otq_pkg::action_t a, logic [62:0] d, logic [62:0] v,
			logic [31:0] t, logic [62:0] n);
		req_t r;
		r.act = a; r.dl = d; r.iv = v; r.tid = t; r.now = n;
		return r;
	endfunction

	function automatic logic [62:0] rand63();
		return 63'({$urandom, $urandom});
	endfunction

	// Random deadline: mostly near a small clock, sometimes anywhere
	function automatic logic [62:0] near_time(logic [62:0] base);
		if ($urandom_range(0, 9) == 0) return rand63();
		return base + 63'($urandom_range(0, 200));
	endfunction

	initial begin
		logic [62:0] clock_now;
		int n;
		// directed part
		pending_reqs.push_back(mk(otq_pkg::ACT_TICK, 0, 0, 0, 0));
		pending_reqs.push_back(mk(otq_pkg::ACT_CANCEL, 0, 0, 32'hFFFF_FFFF, 0));
		pending_reqs.push_back(mk(otq_pkg::ACT_ADD, TMAX, TMAX, 0, 0));
		pending_reqs.push_back(mk(otq_pkg::ACT_ADD, 0, 0, 0, 0));
		pending_reqs.push_back(mk(otq_pkg::ACT_ADD, 0, 5, 0, 0));
		pending_reqs.push_back(mk(otq_pkg::ACT_NONE, TMAX, TMAX, 32'hFFFF_FFFF, TMAX));
		pending_reqs.push_back(mk(otq_pkg::ACT_CANCEL, 0, 0, 1, 0));
		pending_reqs.push_back(mk(otq_pkg::ACT_CANCEL, 0, 0, 1, 0));
		pending_reqs.push_back(mk(otq_pkg::ACT_TICK, 0, 0, 0, TMAX));
		pending_reqs.push_back(mk(otq_pkg::ACT_TICK, 0, 0, 0, TMAX));
		// fill past capacity with equal deadlines
		for (int i = 0; i < 17; i++)
			pending_reqs.push_back(mk(otq_pkg::ACT_ADD, 100, 63'(i % 2), 0, 0));
		pending_reqs.push_back(mk(otq_pkg::ACT_TICK, 0, 0, 0, 101));
		pending_reqs.push_back(mk(otq_pkg::ACT_TICK, 0, 0, 0, 200));
		// random part: a slowly advancing clock with adds, cancels and ticks
		clock_now = 200;
		for (int i = 0; i < 251; i++) begin
			n = $urandom_range(0, 9);
			if (n < 5)
				pending_reqs.push_back(mk(otq_pkg::ACT_ADD, near_time(clock_now),
					$urandom_range(0, 3) == 0 ? 63'd0 :
					($urandom_range(0, 15) == 0 ? rand63() : 63'($urandom_range(1, 300))),
					$urandom, rand63()));
			else if (n < 7)
				pending_reqs.push_back(mk(otq_pkg::ACT_CANCEL, rand63(), rand63(),
					$urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, i + 30),
					rand63()));
			else if (n < 9) begin
				clock_now += 63'($urandom_range(0, 150));
				pending_reqs.push_back(mk(otq_pkg::ACT_TICK, rand63(), rand63(), $urandom,
					$urandom_range(0, 20) == 0 ? TMAX : clock_now));
			end else
				pending_reqs.push_back(mk(otq_pkg::action_t'($urandom_range(0, 3)),
					rand63(), rand63(), $urandom, rand63()));
		end
		feeding_done = 1;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		wait (pending_reqs.size() == 0 && expected_replies.size() == 0 && !start);
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_replies.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
